// ===== sv/fmocb_pkg.sv =====
// Shared types and constants for the FM-index occurrence checkpoint builder.
// No dependencies; every other file of the block imports this package.
package fmocb_pkg;

  localparam int SYMBOL_W    = 3;
  localparam int ALPHA_W     = 3;
  localparam int KIND_W      = 2;
  localparam int SLOT_W      = 4;
  localparam int ROW_W       = 27;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(4);

  localparam int DEF_CHECKPOINT_GAP = 64;
  localparam int DEF_SYMBOL_SLOTS   = 8;
  localparam int DEF_COUNT_BITS     = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_COUNT = 2'd0,
    KIND_START = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_ERR,
    ST_END,
    ST_ENDROW,
    ST_CUM
  } state_t;

  // Control broadcast from the sequencer to every count cell.
  typedef struct packed {
    logic load;   // copy count into the shadow stage
    logic shift;  // move shadow values one cell toward cell 0
    logic clear;  // zero the count
  } cell_ctrl_t;

endpackage

// ===== sv/fmocb_in_if.sv =====
// Input channel of the checkpoint builder: one transformed-text symbol per beat.
// Depends on fmocb_pkg for the field widths.
interface fmocb_in_if;
  import fmocb_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                end_of_text;

  modport source (output valid, output symbol, output end_of_text, input ready);
  modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

// ===== sv/fmocb_out_if.sv =====
// Result channel of the checkpoint builder: one count, start entry or error per beat.
// Depends on fmocb_pkg for the field widths and the kind codes.
interface fmocb_out_if;
  import fmocb_pkg::*;

  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [SLOT_W-1:0]  slot;
  logic [ROW_W-1:0]   row;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output kind, output slot, output row, output value,
                  output last, input ready);
  modport sink   (input valid, input kind, input slot, input row, input value,
                  input last, output ready);
endinterface

// ===== sv/fm_occurrence_checkpoint_builder_core.sv =====
// FM-index sampled occurrence table builder, top level.
// Input channel in_ch: one BWT symbol per beat (0 = delimiter, 1..alphabet_size
//   letters), end_of_text on the final symbol of a text.
// Result channel out_ch: checkpoint counts (kind 0), start table entries (kind 1)
//   and invalid-symbol errors (kind 2); last marks the final result of a beat.
// cfg_we/cfg_wdata write alphabet_size; write only while the block is idle.
// A symbol that causes no result leaves the sequencer idle, so such beats stream
//   at one per clock. A checkpoint row, an error and the start table of an
//   end-of-text beat hold in_ch.ready low while emitted; the count chain shifts
//   its snapshot out one cell per cycle, while the receiver takes results, into
//   a single output register. The first result of a beat passes from the state
//   register into the output register; an end-of-text beat that opens with the
//   start table first passes the end state. A stalled receiver holds the output
//   register; a sequencer with results left to emit then waits with in_ch.ready
//   low. Reset (synchronous, active low) zeroes all counts and the position and
//   sets alphabet_size to 4; no clearing pass is needed.
// Depends on fmocb_pkg, fmocb_in_if, fmocb_out_if, fmocb_cell and fmocb_seq.
module fm_occurrence_checkpoint_builder_core #(
  parameter int CHECKPOINT_GAP = fmocb_pkg::DEF_CHECKPOINT_GAP,
  parameter int SYMBOL_SLOTS   = fmocb_pkg::DEF_SYMBOL_SLOTS,
  parameter int COUNT_BITS     = fmocb_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fmocb_in_if.sink                       in_ch,
  fmocb_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [fmocb_pkg::ALPHA_W-1:0]  cfg_wdata
);
  import fmocb_pkg::*;

  localparam int COUNT_W = (COUNT_BITS < VALUE_W) ? COUNT_BITS : VALUE_W;

  cell_ctrl_t               ctrl;
  logic [SYMBOL_SLOTS-1:0]  inc;
  logic [COUNT_W-1:0]       shadow_w [SYMBOL_SLOTS+1];

  // the tail feeds zeros into the shadow chain
  assign shadow_w[SYMBOL_SLOTS] = '0;

  for (genvar i = 0; i < SYMBOL_SLOTS; i++) begin : g_cell
    fmocb_cell #(
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .inc        (inc[i]),
      .shadow_in  (shadow_w[i+1]),
      .shadow_out (shadow_w[i])
    );
  end

  fmocb_seq #(
    .CHECKPOINT_GAP (CHECKPOINT_GAP),
    .SYMBOL_SLOTS   (SYMBOL_SLOTS),
    .COUNT_W        (COUNT_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .shadow_head (shadow_w[0]),
    .ctrl        (ctrl),
    .inc         (inc)
  );

endmodule

// ===== sv/fmocb_cell.sv =====
// One cell of the count chain: a saturating symbol count and a shadow stage
// that snapshots the count and shifts toward cell 0. Depends on fmocb_pkg.
module fmocb_cell #(
  parameter int COUNT_W = fmocb_pkg::DEF_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fmocb_pkg::cell_ctrl_t   ctrl,
  input  logic                    inc,
  input  logic [COUNT_W-1:0]      shadow_in,
  output logic [COUNT_W-1:0]      shadow_out
);
  import fmocb_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] shadow_r, shadow_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (inc && (count_r != '1)) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_comb begin
    shadow_nxt = shadow_r;
    if (ctrl.load) begin
      shadow_nxt = count_r;
    end else if (ctrl.shift) begin
      shadow_nxt = shadow_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shadow_r <= shadow_nxt;
  end

  assign shadow_out = shadow_r;

endmodule

// ===== sv/fmocb_seq.sv =====
// Sequencer of the checkpoint builder: position tracking, item handshake,
// result ordering and the output register. Depends on fmocb_pkg and both interfaces.
module fmocb_seq #(
  parameter int CHECKPOINT_GAP = fmocb_pkg::DEF_CHECKPOINT_GAP,
  parameter int SYMBOL_SLOTS   = fmocb_pkg::DEF_SYMBOL_SLOTS,
  parameter int COUNT_W        = fmocb_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fmocb_in_if.sink                       in_ch,
  fmocb_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [fmocb_pkg::ALPHA_W-1:0]  cfg_wdata,
  input  logic [COUNT_W-1:0]             shadow_head,
  output fmocb_pkg::cell_ctrl_t          ctrl,
  output logic [SYMBOL_SLOTS-1:0]        inc
);
  import fmocb_pkg::*;

  localparam int OFF_W = (CHECKPOINT_GAP > 1) ? $clog2(CHECKPOINT_GAP) : 1;
  localparam int IDX_W = $clog2(SYMBOL_SLOTS + 1);

  state_t                state_r, state_nxt;
  logic [ALPHA_W-1:0]    alpha_r;
  logic [IDX_W-1:0]      top_r, top_nxt, top_p1;
  logic [SYMBOL_W-1:0]   sym_r, sym_nxt;
  logic                  err_r, err_nxt;
  logic                  end_r, end_nxt;
  logic [ROW_W-1:0]      item_row_r, item_row_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [OFF_W-1:0]      offset_r, offset_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [COUNT_W-1:0]    sum_r, sum_nxt;
  logic [COUNT_W:0]      sum_wide;
  logic [COUNT_W-1:0]    sum_sat;

  logic                  out_valid_r, out_valid_nxt;
  kind_t                 out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [ROW_W-1:0]      out_row_r, out_row_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  logic                  can_emit;
  logic                  emit;
  logic [IDX_W-1:0]      top_in;
  logic                  err_in;

  assign accept   = in_ch.valid && in_ch.ready;
  assign can_emit = !out_valid_r || out_ch.ready;
  assign top_p1   = top_r + IDX_W'(1);

  assign sum_wide = {1'b0, sum_r} + {1'b0, shadow_head};
  assign sum_sat  = sum_wide[COUNT_W] ? '1 : sum_wide[COUNT_W-1:0];

  always_comb begin
    if (32'(alpha_r) > SYMBOL_SLOTS - 1) begin
      top_in = IDX_W'(SYMBOL_SLOTS - 1);
    end else begin
      top_in = IDX_W'(alpha_r);
    end
    err_in = 32'(in_ch.symbol) > 32'(top_in);
  end

  always_comb begin
    for (int i = 0; i < SYMBOL_SLOTS; i++) begin
      inc[i] = accept && !err_in && (32'(in_ch.symbol) == i);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    sym_nxt       = sym_r;
    err_nxt       = err_r;
    end_nxt       = end_r;
    item_row_nxt  = item_row_r;
    idx_nxt       = idx_r;
    offset_nxt    = offset_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    ctrl          = '0;
    emit          = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_row_nxt   = out_row_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    in_ch.ready   = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          top_nxt      = top_in;
          sym_nxt      = in_ch.symbol;
          err_nxt      = err_in;
          end_nxt      = in_ch.end_of_text;
          item_row_nxt = row_r;
          // snapshot before this symbol is counted
          ctrl.load    = (offset_r == '0);
          if (pos_r == '1) begin
            pos_nxt    = '0;
            offset_nxt = '0;
            row_nxt    = '0;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
            if (offset_r == OFF_W'(CHECKPOINT_GAP - 1)) begin
              offset_nxt = '0;
              row_nxt    = row_r + ROW_W'(1);
            end else begin
              offset_nxt = offset_r + OFF_W'(1);
            end
          end
          if (offset_r == '0) begin
            state_nxt = ST_ROW;
          end else if (err_in) begin
            state_nxt = ST_ERR;
          end else if (in_ch.end_of_text) begin
            state_nxt = ST_END;
          end
        end
      end

      ST_ROW, ST_ENDROW: begin
        if (can_emit) begin
          emit          = 1'b1;
          ctrl.shift    = 1'b1;
          out_kind_nxt  = KIND_COUNT;
          out_slot_nxt  = SLOT_W'(idx_r);
          out_row_nxt   = (state_r == ST_ROW) ? item_row_r : row_r;
          out_value_nxt = VALUE_W'(shadow_head);
          out_last_nxt  = 1'b0;
          idx_nxt       = idx_r + IDX_W'(1);
          if (idx_r == top_r) begin
            idx_nxt = '0;
            if (state_r == ST_ENDROW) begin
              // reload for the start table and drop the text state
              ctrl.load  = 1'b1;
              ctrl.shift = 1'b0;
              ctrl.clear = 1'b1;
              pos_nxt    = '0;
              offset_nxt = '0;
              row_nxt    = '0;
              sum_nxt    = '0;
              state_nxt  = ST_CUM;
            end else begin
              out_last_nxt = !err_r && !end_r;
              if (err_r) begin
                state_nxt = ST_ERR;
              end else if (end_r) begin
                state_nxt = ST_END;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end

      ST_ERR: begin
        if (can_emit) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_ERROR;
          out_slot_nxt  = SLOT_W'(sym_r);
          out_row_nxt   = item_row_r;
          out_value_nxt = '0;
          out_last_nxt  = !end_r;
          state_nxt     = end_r ? ST_END : ST_IDLE;
        end
      end

      ST_END: begin
        idx_nxt   = '0;
        ctrl.load = 1'b1;
        if (offset_r == '0) begin
          state_nxt = ST_ENDROW;
        end else begin
          ctrl.clear = 1'b1;
          pos_nxt    = '0;
          offset_nxt = '0;
          row_nxt    = '0;
          sum_nxt    = '0;
          state_nxt  = ST_CUM;
        end
      end

      ST_CUM: begin
        if (can_emit) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_START;
          out_slot_nxt = SLOT_W'(idx_r);
          out_row_nxt  = '0;
          out_last_nxt = (idx_r == top_p1);
          idx_nxt      = idx_r + IDX_W'(1);
          if (idx_r == '0) begin
            out_value_nxt = '0;
          end else begin
            ctrl.shift    = 1'b1;
            sum_nxt       = sum_sat;
            out_value_nxt = VALUE_W'(sum_sat);
          end
          if (idx_r == top_p1) begin
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alpha_r     <= ALPHA_RESET;
      idx_r       <= '0;
      offset_r    <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      offset_r    <= offset_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        alpha_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    sym_r       <= sym_nxt;
    err_r       <= err_nxt;
    end_r       <= end_nxt;
    item_row_r  <= item_row_nxt;
    sum_r       <= sum_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_row_r   <= out_row_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.slot  = out_slot_r;
  assign out_ch.row   = out_row_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit && out_valid_r && !out_ch.ready))
    else $error("result register overwritten while stalled");

  a_count_not_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |-> (inc == '0))
    else $error("count increment collides with clear");

  a_inc_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(inc) && ((inc == '0) || accept))
    else $error("count increment outside an accepted beat");

  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CUM && idx_r == '0 && can_emit) |=>
      (out_valid_r && out_kind_r == KIND_START && out_value_r == '0))
    else $error("start table does not open with zero");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (idx_r <= top_p1))
    else $error("slot index past the table end");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for fm_occurrence_checkpoint_builder_core: checkpoint rows,
// start table, invalid-symbol errors. Needs fmocb_pkg, fmocb_in_if, fmocb_out_if and the core.
module tb_top;
  import fmocb_pkg::*;

  localparam int unsigned GAP        = DEF_CHECKPOINT_GAP;
  localparam int unsigned SLOTS      = DEF_SYMBOL_SLOTS;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned SETTLE     = 12;
  localparam int unsigned LONG_HOLD  = 300;

  typedef struct {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [ROW_W-1:0]   row;
    logic [VALUE_W-1:0] value;
    logic               last;
  } occ_result_t;

  class occ_scoreboard;
    logic [VALUE_W-1:0] counts [SLOTS];
    logic [POS_W-1:0]   pos;
    logic [ALPHA_W-1:0] alpha;
    occ_result_t        batch [$];
    occ_result_t        pending_results [$];
    int unsigned        mismatches;

    function new();
      foreach (counts[i]) counts[i] = '0;
      pos = '0;
      alpha = ALPHA_RESET;
      mismatches = 0;
    endfunction

    function void set_alpha(logic [ALPHA_W-1:0] v);
      alpha = v;
    endfunction

    function int unsigned letters();
      return (alpha > SLOTS - 1) ? SLOTS - 1 : int'(alpha);
    endfunction

    function logic [VALUE_W-1:0] sat_sum(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
      logic [VALUE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VALUE_W] ? '1 : s[VALUE_W-1:0];
    endfunction

    function void emit(kind_t k, int unsigned slot, logic [POS_W-1:0] p,
                       logic [VALUE_W-1:0] v);
      occ_result_t r;
      r.kind  = k;
      r.slot  = SLOT_W'(slot);
      r.row   = ROW_W'(p / GAP);
      r.value = v;
      r.last  = 1'b0;
      batch = {batch, r};
    endfunction

    function void emit_row(logic [POS_W-1:0] p);
      for (int unsigned s = 0; s <= letters(); s++) emit(KIND_COUNT, s, p, counts[s]);
    endfunction

    // Advance the occurrence state by one accepted symbol and queue what it causes.
    function void absorb_symbol(logic [SYMBOL_W-1:0] sym, logic eot);
      logic [VALUE_W-1:0] sum;
      occ_result_t r;
      batch.delete();
      if (pos % GAP == 0) emit_row(pos);
      if (sym > letters()) emit(KIND_ERROR, sym, pos, '0);
      else counts[sym] = sat_sum(counts[sym], 1);
      pos = pos + 1;
      if (eot) begin
        if (pos % GAP == 0) emit_row(pos);
        emit(KIND_START, 0, '0, '0);
        sum = counts[0];
        emit(KIND_START, 1, '0, sum);
        for (int unsigned k = 1; k <= letters(); k++) begin
          sum = sat_sum(sum, counts[k]);
          emit(KIND_START, k + 1, '0, sum);
        end
        foreach (counts[i]) counts[i] = '0;
        pos = '0;
      end
      foreach (batch[i]) begin
        r = batch[i];
        r.last = (i == batch.size() - 1);
        pending_results = {pending_results, r};
      end
    endfunction

    function void compare_result(kind_t k, logic [SLOT_W-1:0] slot, logic [ROW_W-1:0] row,
                                 logic [VALUE_W-1:0] value, logic last);
      occ_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d row %0d value %0d last %0d",
               k, slot, row, value, last);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, k);
        mismatches++;
      end
      if (slot !== e.slot) begin
        $error("slot: expected %0d, got %0d", e.slot, slot);
        mismatches++;
      end
      if (row !== e.row) begin
        $error("row: expected %0d, got %0d", e.row, row);
        mismatches++;
      end
      if (value !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, value);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ALPHA_W-1:0] cfg_wdata;
  int unsigned cycle_count = 0;
  bit hold_results = 1'b0;
  int text_left = 0;

  occ_scoreboard sb = new();

  fmocb_in_if  in_ch();
  fmocb_out_if out_ch();

  fm_occurrence_checkpoint_builder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: random stalls per beat, one long hold on request.
  initial begin : result_sink
    int unsigned pause;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pause = $urandom_range(0, 4);
      if (hold_results) begin
        pause = LONG_HOLD;
        hold_results = 1'b0;
      end
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      sb.compare_result(out_ch.kind, out_ch.slot, out_ch.row, out_ch.value, out_ch.last);
    end
  end

  task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic eot);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= sym;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    sb.absorb_symbol(sym, eot);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [ALPHA_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_alpha(v);
  endtask

  // Random text: mostly letters of the current alphabet, some stray codes.
  task automatic send_random(input int unsigned n_items);
    logic [SYMBOL_W-1:0] sym;
    int unsigned pick;
    repeat (n_items) begin
      if (text_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) text_left = GAP;
        else if (pick < 40) text_left = $urandom_range(GAP + 1, 2 * GAP + 2);
        else text_left = $urandom_range(1, 16);
      end
      if ($urandom_range(0, 99) < 85) sym = SYMBOL_W'($urandom_range(0, sb.letters()));
      else sym = SYMBOL_W'($urandom_range(0, 7));
      send_symbol(sym, text_left == 1);
      text_left--;
    end
  endtask

  initial begin : stimulus
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.symbol      <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset alphabet: every letter, two stray codes, then close the text.
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd2, 1'b0);
    send_symbol(3'd3, 1'b0);
    send_symbol(3'd4, 1'b0);
    send_symbol(3'd5, 1'b0);
    send_symbol(3'd7, 1'b0);
    send_symbol(3'd2, 1'b1);
    // One-symbol text, and a stray code that ends a text.
    send_symbol(3'd0, 1'b1);
    send_symbol(3'd6, 1'b1);

    // Delimiter only.
    write_alpha(3'd0);
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd0, 1'b1);

    // Full alphabet.
    write_alpha(3'd7);
    send_symbol(3'd7, 1'b0);
    send_symbol(3'd6, 1'b0);
    send_symbol(3'd5, 1'b0);
    send_symbol(3'd0, 1'b1);

    // Shrink the alphabet inside a text; upper counts drop out of the table.
    send_symbol(3'd3, 1'b0);
    send_symbol(3'd7, 1'b0);
    send_symbol(3'd7, 1'b0);
    write_alpha(3'd2);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd7, 1'b0);
    send_symbol(3'd0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_alpha(3'd7);
        1: write_alpha(3'd0);
        5: write_alpha(3'd1);
        default: write_alpha(ALPHA_W'($urandom_range(1, 7)));
      endcase
      if (p == 2) hold_results = 1'b1;
      send_random(30);
    end
    // Close whatever text is still open.
    send_symbol(3'd0, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
